[design/lhd_pkg.sv]
// Shared types and constants for the link disconnect handshake unit.
package lhd_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_LINK_ROLE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ADDRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd3;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] CTRL_DISC = 8'h0B;
  localparam logic [7:0] CTRL_UA   = 8'h07;

  localparam logic [7:0]  RST_FRAME_ADDRESS = 8'h03;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd3;
  localparam logic [3:0]  RST_MAX_ATTEMPTS  = 4'd3;
  localparam logic [3:0]  TIMEOUT_SAT       = 4'hF;

  // Slot numbers within one frame transfer sequence
  localparam logic [2:0] SLOT_FLAG   = 3'd0;
  localparam logic [2:0] SLOT_ADDR   = 3'd1;
  localparam logic [2:0] SLOT_CTRL   = 3'd2;
  localparam logic [2:0] SLOT_CHECK  = 3'd3;
  localparam logic [2:0] SLOT_FIFTH  = 3'd4;
  localparam logic [2:0] SLOT_STATUS = 3'd5;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_TX_WAIT  = 2'd1,
    PH_RX_DISC  = 2'd2,
    PH_RX_REPLY = 2'd3
  } phase_t;

  typedef struct packed {
    logic       has_frame;
    logic [7:0] ctrl;
    logic [7:0] addr;
    logic [7:0] fifth;
    logic       has_stat;
    kind_t      stat;
  } job_t;

endpackage

[design/link_disconnect_handshake_unit.sv]
// Top level of the link disconnect handshake unit.
//
//  channel   handshake              payload
//  in        in_valid / in_ready    in_operation[1:0], in_rx_byte[7:0]
//  out       out_valid / out_ready  out_kind[1:0], out_tx_byte[7:0], out_last
//  cfg       cfg_we                 cfg_index[1:0], cfg_data[15:0]
//
// An input transfer is taken every cycle while the job queue has room; the front end
// updates the handshake state in that same cycle and queues at most one job.
// The result sequencer sends one result per cycle from its output register while
// out_ready is high; a job gives one to six results (six for a UA frame plus status).
// Reset is synchronous and active low; no clearing pass follows it.
// A stalled result channel fills the queue and then holds in_ready low.
module link_disconnect_handshake_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lhd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lhd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_operation,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_last
);

  logic          q_full;
  logic          push;
  lhd_pkg::job_t push_job;
  logic          pop;
  logic          head_valid;
  lhd_pkg::job_t head_job;

  lhd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  lhd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_job)
  );

  lhd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

endmodule

[design/lhd_front.sv]
// Front end: configuration registers, input acceptance and handshake state machine.
module lhd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lhd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lhd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [7:0]                          in_rx_byte,
  input  logic                                q_full,
  output logic                                push,
  output lhd_pkg::job_t                       job
);

  logic            role_r, role_nxt;
  logic [7:0]      faddr_r, faddr_nxt;
  logic [15:0]     ticks_r, ticks_nxt;
  logic [3:0]      maxatt_r, maxatt_nxt;
  lhd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      pos_r, pos_nxt;
  logic [15:0]     timer_r, timer_nxt;
  logic [3:0]      tcount_r, tcount_nxt;
  logic [7:0]      saddr_r, saddr_nxt;
  logic [7:0]      sctrl_r, sctrl_nxt;
  logic [7:0]      schk_r, schk_nxt;

  logic        accept;
  logic        is_start;
  logic        is_byte;
  logic        is_tick;
  logic        byte_live;
  logic        frame_done;
  logic        disc_ok;
  logic        timed;
  logic [15:0] timer_inc;
  logic        expire;
  logic [3:0]  tcount_inc;
  logic        give_up;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign is_start   = accept && (in_operation == lhd_pkg::OP_START);
  assign is_byte    = accept && (in_operation == lhd_pkg::OP_BYTE);
  assign is_tick    = accept && (in_operation == lhd_pkg::OP_TICK);
  assign byte_live  = is_byte && (phase_r != lhd_pkg::PH_IDLE);
  assign frame_done = byte_live && (pos_r == lhd_pkg::SLOT_FIFTH);
  assign disc_ok    = (schk_r == (saddr_r ^ sctrl_r)) && (sctrl_r == lhd_pkg::CTRL_DISC);
  assign timed      = (phase_r == lhd_pkg::PH_TX_WAIT) || (phase_r == lhd_pkg::PH_RX_REPLY);
  assign timer_inc  = timer_r + 16'd1;
  assign expire     = is_tick && timed && !(timer_inc < ticks_r);
  assign tcount_inc = (tcount_r == lhd_pkg::TIMEOUT_SAT) ? tcount_r : tcount_r + 4'd1;
  assign give_up    = (tcount_inc >= maxatt_r);

  always_comb begin
    role_nxt   = role_r;
    faddr_nxt  = faddr_r;
    ticks_nxt  = ticks_r;
    maxatt_nxt = maxatt_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    timer_nxt  = timer_r;
    tcount_nxt = tcount_r;
    saddr_nxt  = saddr_r;
    sctrl_nxt  = sctrl_r;
    schk_nxt   = schk_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lhd_pkg::CFG_LINK_ROLE:     role_nxt   = cfg_data[0];
        lhd_pkg::CFG_FRAME_ADDRESS: faddr_nxt  = cfg_data[7:0];
        lhd_pkg::CFG_TIMEOUT_TICKS: ticks_nxt  = cfg_data[15:0];
        lhd_pkg::CFG_MAX_ATTEMPTS:  maxatt_nxt = cfg_data[3:0];
        default: ;
      endcase
    end
    if (is_start) begin
      tcount_nxt = 4'd0;
      phase_nxt  = role_r ? lhd_pkg::PH_RX_DISC : lhd_pkg::PH_TX_WAIT;
      pos_nxt    = 3'd0;
      timer_nxt  = 16'd0;
    end else if (byte_live) begin
      if (pos_r == lhd_pkg::SLOT_FLAG) begin
        if (in_rx_byte == lhd_pkg::FLAG_BYTE) begin
          pos_nxt = lhd_pkg::SLOT_ADDR;
        end
      end else if (pos_r != lhd_pkg::SLOT_FIFTH) begin
        case (pos_r)
          lhd_pkg::SLOT_ADDR: saddr_nxt = in_rx_byte;
          lhd_pkg::SLOT_CTRL: sctrl_nxt = in_rx_byte;
          default:            schk_nxt  = in_rx_byte;
        endcase
        pos_nxt = pos_r + 3'd1;
      end else begin
        pos_nxt = 3'd0;
        unique case (phase_r)
          lhd_pkg::PH_TX_WAIT: begin
            if (disc_ok) begin
              phase_nxt = lhd_pkg::PH_IDLE;
              timer_nxt = 16'd0;
            end
          end
          lhd_pkg::PH_RX_DISC: begin
            if (disc_ok) begin
              phase_nxt = lhd_pkg::PH_RX_REPLY;
              timer_nxt = 16'd0;
            end
          end
          lhd_pkg::PH_RX_REPLY: begin
            phase_nxt = lhd_pkg::PH_IDLE;
            timer_nxt = 16'd0;
          end
          default: ;
        endcase
      end
    end else if (is_tick && timed) begin
      if (!expire) begin
        timer_nxt = timer_inc;
      end else begin
        tcount_nxt = tcount_inc;
        timer_nxt  = 16'd0;
        pos_nxt    = 3'd0;
        if (give_up) begin
          phase_nxt = lhd_pkg::PH_IDLE;
        end else if (phase_r == lhd_pkg::PH_RX_REPLY) begin
          phase_nxt = lhd_pkg::PH_RX_DISC;
        end
      end
    end
  end

  always_comb begin
    push          = 1'b0;
    job.has_frame = 1'b0;
    job.ctrl      = lhd_pkg::CTRL_DISC;
    job.addr      = faddr_r;
    job.fifth     = lhd_pkg::FLAG_BYTE;
    job.has_stat  = 1'b0;
    job.stat      = lhd_pkg::KIND_FAIL;
    if (is_start) begin
      if (!role_r) begin
        push          = 1'b1;
        job.has_frame = 1'b1;
      end
    end else if (frame_done) begin
      unique case (phase_r)
        lhd_pkg::PH_TX_WAIT: begin
          if (disc_ok) begin
            push          = 1'b1;
            job.has_frame = 1'b1;
            job.ctrl      = lhd_pkg::CTRL_UA;
            job.addr      = saddr_r;
            job.fifth     = in_rx_byte;
            job.has_stat  = 1'b1;
            job.stat      = lhd_pkg::KIND_OK;
          end
        end
        lhd_pkg::PH_RX_DISC: begin
          if (disc_ok) begin
            push          = 1'b1;
            job.has_frame = 1'b1;
            job.ctrl      = sctrl_r;
            job.addr      = saddr_r;
            job.fifth     = in_rx_byte;
          end
        end
        lhd_pkg::PH_RX_REPLY: begin
          push         = 1'b1;
          job.has_stat = 1'b1;
          job.stat     = (sctrl_r == lhd_pkg::CTRL_UA) ? lhd_pkg::KIND_OK : lhd_pkg::KIND_FAIL;
        end
        default: ;
      endcase
    end else if (expire) begin
      if (give_up) begin
        push         = 1'b1;
        job.has_stat = 1'b1;
      end else if (phase_r == lhd_pkg::PH_TX_WAIT) begin
        push          = 1'b1;
        job.has_frame = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r   <= 1'b0;
      faddr_r  <= lhd_pkg::RST_FRAME_ADDRESS;
      ticks_r  <= lhd_pkg::RST_TIMEOUT_TICKS;
      maxatt_r <= lhd_pkg::RST_MAX_ATTEMPTS;
      phase_r  <= lhd_pkg::PH_IDLE;
      pos_r    <= 3'd0;
      timer_r  <= 16'd0;
      tcount_r <= 4'd0;
    end else begin
      role_r   <= role_nxt;
      faddr_r  <= faddr_nxt;
      ticks_r  <= ticks_nxt;
      maxatt_r <= maxatt_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      timer_r  <= timer_nxt;
      tcount_r <= tcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    saddr_r <= saddr_nxt;
    sctrl_r <= sctrl_nxt;
    schk_r  <= schk_nxt;
  end

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lhd_pkg::PH_IDLE) |-> (pos_r == 3'd0) && (timer_r == 16'd0))
    else $error("idle phase with live frame position or timer");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= lhd_pkg::SLOT_FIFTH)
    else $error("frame position out of range");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_start |=> (tcount_r == 4'd0) && (phase_r != lhd_pkg::PH_IDLE))
    else $error("start did not clear timeout count or enter a wait");
`endif

endmodule

[design/lhd_queue.sv]
// Job queue between the front end and the result sequencer.
module lhd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lhd_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lhd_pkg::job_t head_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  lhd_pkg::job_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

[design/lhd_back.sv]
// Result sequencer: expands queued jobs into transfers on the result channel.
module lhd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  lhd_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_tx_byte,
  output logic          out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_tx_byte_r, out_tx_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic       load;
  logic [2:0] slot;
  logic       is_last;

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign slot    = head.has_frame ? idx_r : lhd_pkg::SLOT_STATUS;
  assign is_last = (slot == lhd_pkg::SLOT_STATUS) ||
                   ((slot == lhd_pkg::SLOT_FIFTH) && !head.has_stat);
  assign pop     = load && is_last;

  always_comb begin
    out_kind_nxt    = lhd_pkg::KIND_BYTE;
    out_tx_byte_nxt = 8'd0;
    case (slot)
      lhd_pkg::SLOT_FLAG:  out_tx_byte_nxt = lhd_pkg::FLAG_BYTE;
      lhd_pkg::SLOT_ADDR:  out_tx_byte_nxt = head.addr;
      lhd_pkg::SLOT_CTRL:  out_tx_byte_nxt = head.ctrl;
      lhd_pkg::SLOT_CHECK: out_tx_byte_nxt = head.addr ^ head.ctrl;
      lhd_pkg::SLOT_FIFTH: out_tx_byte_nxt = head.fifth;
      default:             out_kind_nxt    = head.stat;
    endcase
    out_last_nxt = is_last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 3'd0 : slot + 3'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r    <= out_kind_nxt;
      out_tx_byte_r <= out_tx_byte_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_tx_byte = out_tx_byte_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && out_last_r)
    else $error("job retired without a final transfer");
`endif

endmodule
